/* design/iptq_pkg.sv */
package iptq_pkg;

    // index width for the largest supported store
    localparam int IDX_W = 10;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_EDIT   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXEC   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_DUP       = 3'd4
    } status_t;

    // partial search result passed from cell to cell
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
        logic             best_ok;
        logic [IDX_W-1:0] best_idx;
        logic [31:0]      best_pri;
        logic [15:0]      best_task;
        logic [15:0]      best_user;
    } wave_t;

    // write broadcast to all cells
    typedef struct packed {
        logic             en;
        opcode_t          op;
        logic [IDX_W-1:0] idx;
        logic [15:0]      task_id;
        logic [15:0]      user_id;
        logic [31:0]      pri;
    } commit_t;

endpackage

/* design/iptq_cell.sv */
module iptq_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         key_task,
    input  iptq_pkg::wave_t     wave_in,
    output iptq_pkg::wave_t     wave_out,
    input  iptq_pkg::commit_t   commit
);

    localparam logic [iptq_pkg::IDX_W-1:0] MY_IDX = IDX[iptq_pkg::IDX_W-1:0];

    logic        valid_reg;
    logic [15:0] task_reg;
    logic [15:0] user_reg;
    logic [31:0] pri_reg;
    iptq_pkg::wave_t wave_reg;
    iptq_pkg::wave_t wave_next;
    logic        hit;

    assign hit = commit.en && (commit.idx == MY_IDX);

    always_comb
    begin
        wave_next = wave_in;
        if (valid_reg && task_reg == key_task && !wave_in.found)
        begin
            wave_next.found     = 1'b1;
            wave_next.found_idx = MY_IDX;
        end
        if (!valid_reg && !wave_in.free_ok)
        begin
            wave_next.free_ok  = 1'b1;
            wave_next.free_idx = MY_IDX;
        end
        if (valid_reg && (!wave_in.best_ok || pri_reg > wave_in.best_pri ||
            (pri_reg == wave_in.best_pri && task_reg > wave_in.best_task)))
        begin
            wave_next.best_ok   = 1'b1;
            wave_next.best_idx  = MY_IDX;
            wave_next.best_pri  = pri_reg;
            wave_next.best_task = task_reg;
            wave_next.best_user = user_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            case (commit.op)
                iptq_pkg::OP_ADD:    valid_reg <= 1'b1;
                iptq_pkg::OP_EDIT:   valid_reg <= valid_reg;
                default:             valid_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
        if (hit && commit.op == iptq_pkg::OP_ADD)
        begin
            task_reg <= commit.task_id;
            user_reg <= commit.user_id;
            pri_reg  <= commit.pri;
        end
        else if (hit && commit.op == iptq_pkg::OP_EDIT)
        begin
            pri_reg <= commit.pri;
        end
    end

    assign wave_out = wave_reg;

endmodule

/* design/indexed_priority_task_queue_unit.sv */
// channel | signals                                       | accepted when
// in      | in_valid in_ready opcode task_id user_id       | in_valid && in_ready
//         | priority_req                                  |
// out     | out_valid out_ready status served_user        | out_valid && out_ready
//         | served_task                                   |
// a result shows once the search wave has stepped through the cell chain
// one cell per cycle and the commit state has written the result register
// one item at a time: a new item is accepted only in the idle state
// a new item is taken while the last result waits
// reset clears all slot valid bits and the control state, no clearing pass
// a stalled output holds the commit until the result register frees
module indexed_priority_task_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [15:0] user_id,
    input  logic [31:0] priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] served_user,
    output logic [15:0] served_task
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // command held for the whole search
    iptq_pkg::opcode_t op_reg;
    logic [15:0] task_reg;
    logic [15:0] user_reg;
    logic [31:0] pri_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg;
    logic [15:0] suser_reg;
    logic [15:0] stask_reg;

    iptq_pkg::wave_t   wave [CAPACITY+1];
    iptq_pkg::commit_t commit;
    iptq_pkg::status_t st;
    iptq_pkg::wave_t   res;

    logic accept;
    logic fire;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    // fresh wave enters the chain every cycle
    assign wave[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            iptq_cell #(.IDX(g)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .key_task (task_reg),
                .wave_in  (wave[g]),
                .wave_out (wave[g+1]),
                .commit   (commit)
            );
        end
    endgenerate

    assign res = wave[CAPACITY];

    // decide status and the slot to write
    always_comb
    begin
        st          = iptq_pkg::ST_OK;
        commit      = '0;
        commit.op   = op_reg;
        commit.task_id = task_reg;
        commit.user_id = user_reg;
        commit.pri  = pri_reg;
        case (op_reg)
            iptq_pkg::OP_ADD:
            begin
                if (res.found)
                    st = iptq_pkg::ST_DUP;
                else if (!res.free_ok)
                    st = iptq_pkg::ST_FULL;
                commit.idx = res.free_idx;
            end
            iptq_pkg::OP_EDIT, iptq_pkg::OP_REMOVE:
            begin
                if (!res.found)
                    st = iptq_pkg::ST_NOT_FOUND;
                commit.idx = res.found_idx;
            end
            default:
            begin
                if (!res.best_ok)
                    st = iptq_pkg::ST_EMPTY;
                commit.idx = res.best_idx;
            end
        endcase
        commit.en = fire && (st == iptq_pkg::ST_OK);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST)
                    state_next = S_COMMIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_COMMIT:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= iptq_pkg::opcode_t'(opcode);
            task_reg <= task_id;
            user_reg <= user_id;
            pri_reg  <= priority_req;
        end
        if (fire)
        begin
            status_reg <= st;
            if (op_reg == iptq_pkg::OP_EXEC && st == iptq_pkg::ST_OK)
            begin
                suser_reg <= res.best_user;
                stask_reg <= res.best_task;
            end
            else
            begin
                suser_reg <= '0;
                stask_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign served_user = suser_reg;
    assign served_task = stask_reg;

endmodule

/* design/iptq_checker.sv */
module iptq_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] served_user,
    input logic [15:0] served_task
);

    // result status and served task hold while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(served_task))
        else $error("result changed while stalled");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(iptq_pkg::ST_DUP))
        else $error("bad status code");

    // a failed result carries zero ids
    a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'(iptq_pkg::ST_OK) |->
            served_user == 16'd0 && served_task == 16'd0)
        else $error("ids on failed result");

    // an accepted item blocks further input next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken during search");

endmodule

bind indexed_priority_task_queue_unit iptq_props u_iptq_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .served_user (served_user),
    .served_task (served_task)
);
